/* rtl/core/bitmap_allocator_defines.svh */
// ----------------------------------------------------------------------------
// bitmap_allocator_defines.svh
// Assertion macros used by the bitmap allocator controller (bma_ctrl).
// ----------------------------------------------------------------------------
`ifndef BITMAP_ALLOCATOR_DEFINES_SVH
`define BITMAP_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked on aclk outside reset
`define BMA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on aclk outside reset
`define BMA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bma_pkg.sv */
// ----------------------------------------------------------------------------
// bma_pkg
// Shared types, codes and helpers of the bitmap allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SLOT_W   = 14;
    localparam int TOTAL_W  = 14;
    localparam int COUNT_W  = 32;

    // Default bitmap size in bytes
    localparam int DEF_MAP_BYTES = 1024;

    // Reset values of the size registers
    localparam logic [TOTAL_W-1:0] INODE_TOTAL_RST = 14'd32;
    localparam logic [TOTAL_W-1:0] BLOCK_TOTAL_RST = 14'd128;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_FIND      = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MARK_USED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_MARK_FREE = 2'd2;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_FREE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_SLOT = 2'd2;

    // Map select codes
    localparam logic MAP_INODE = 1'b0;
    localparam logic MAP_BLOCK = 1'b1;

    // Configuration register indexes
    localparam logic REG_INODE_TOTAL = 1'b0;
    localparam logic REG_BLOCK_TOTAL = 1'b1;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              map_select;
        logic [SLOT_W-1:0] slot_number;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   found_number;
        logic [COUNT_W-1:0]  free_count;
    } rsp_t;

    // Write strobes toward the two bitmap memories
    typedef struct packed {
        logic wr_inode;
        logic wr_block;
    } mem_wr_t;

    // Position of the lowest clear bit of a byte (byte must not be all ones)
    function automatic logic [2:0] lowest_zero(input logic [7:0] value);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 7; i >= 0; i--) begin
            if (!value[i]) begin
                pos = 3'(i);
            end
        end
        return pos;
    endfunction

endpackage

/* rtl/core/bma_map_ram.sv */
// ----------------------------------------------------------------------------
// bma_map_ram
// Byte-wide bitmap memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module bma_map_ram #(
    parameter int DEPTH = bma_pkg::DEF_MAP_BYTES
) (
    input  logic                                 aclk,
    input  logic                                 wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [7:0]                           wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [7:0]                           rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write one byte
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read one byte, data valid the next cycle
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/bma_ctrl.sv */
// ----------------------------------------------------------------------------
// bma_ctrl
// Request sequencer: clearing pass, bitmap scan, read-modify-write marking,
// free counters and the result register.
// ----------------------------------------------------------------------------
`include "bitmap_allocator_defines.svh"

module bma_ctrl #(
    parameter int MAP_BYTES = bma_pkg::DEF_MAP_BYTES
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         s_valid,
    output logic                                         s_ready,
    input  bma_pkg::req_t                                s_data,
    output logic                                         m_valid,
    input  logic                                         m_ready,
    output bma_pkg::rsp_t                                m_data,
    input  logic [bma_pkg::TOTAL_W-1:0]                  inode_total,
    input  logic [bma_pkg::TOTAL_W-1:0]                  block_total,
    output bma_pkg::mem_wr_t                             mem_wr,
    output logic [((MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1)-1:0] mem_wr_addr,
    output logic [7:0]                                   mem_wr_data,
    output logic [((MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1)-1:0] mem_rd_addr,
    input  logic [7:0]                                   inode_rd_data,
    input  logic [7:0]                                   block_rd_data
);

    localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam int NB_W   = $clog2(MAP_BYTES + 1);
    localparam int SZ_W   = 17;
    localparam logic [SZ_W-1:0]   CAP       = SZ_W'(MAP_BYTES * 8);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_BYTES - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_MREAD,
        ST_MWRITE,
        ST_FIN
    } state_t;

    state_t                              state_reg, state_next;
    logic [ADDR_W-1:0]                   clr_addr_reg, clr_addr_next;
    logic [bma_pkg::KIND_W-1:0]          kind_reg, kind_next;
    logic                                map_reg, map_next;
    logic [ADDR_W-1:0]                   mark_addr_reg, mark_addr_next;
    logic [2:0]                          mark_bit_reg, mark_bit_next;
    logic [NB_W-1:0]                     nbytes_reg, nbytes_next;
    logic [NB_W-1:0]                     issue_reg, issue_next;
    logic                                pend_reg, pend_next;
    logic [NB_W-1:0]                     pend_addr_reg, pend_addr_next;
    logic [bma_pkg::STATUS_W-1:0]        res_status_reg, res_status_next;
    logic [bma_pkg::SLOT_W-1:0]          res_found_reg, res_found_next;
    logic [bma_pkg::COUNT_W-1:0]         ino_free_reg, ino_free_next;
    logic [bma_pkg::COUNT_W-1:0]         blk_free_reg, blk_free_next;
    logic                                m_valid_reg, m_valid_next;
    bma_pkg::rsp_t                       m_data_reg, m_data_next;

    logic [bma_pkg::TOTAL_W-1:0]         total_sel;
    logic [SZ_W-1:0]                     eff_size;
    logic [bma_pkg::SLOT_W-1:0]          slot_pos;
    logic                                slot_bad;
    logic [7:0]                          rd_byte;
    logic [7:0]                          bit_mask;
    logic [NB_W+2:0]                     found_sum;
    logic [bma_pkg::COUNT_W-1:0]         count_sel;

    // Decode the incoming request against the selected map size
    always_comb begin
        total_sel = (s_data.map_select == bma_pkg::MAP_BLOCK) ? block_total : inode_total;
        eff_size  = ({3'b000, total_sel} > CAP) ? CAP : {3'b000, total_sel};
        slot_pos  = s_data.slot_number - bma_pkg::SLOT_W'(1);
        slot_bad  = (s_data.slot_number == '0) || ({3'b000, s_data.slot_number} > eff_size);
    end

    assign rd_byte   = (map_reg == bma_pkg::MAP_BLOCK) ? block_rd_data : inode_rd_data;
    assign bit_mask  = 8'b0000_0001 << mark_bit_reg;
    assign found_sum = {pend_addr_reg, 3'b000} + (NB_W + 3)'(bma_pkg::lowest_zero(rd_byte))
                     + (NB_W + 3)'(1);
    assign count_sel = (map_reg == bma_pkg::MAP_BLOCK) ? blk_free_reg : ino_free_reg;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Next-state and datapath control
    always_comb begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        kind_next       = kind_reg;
        map_next        = map_reg;
        mark_addr_next  = mark_addr_reg;
        mark_bit_next   = mark_bit_reg;
        nbytes_next     = nbytes_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        pend_addr_next  = pend_addr_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        ino_free_next   = ino_free_reg;
        blk_free_next   = blk_free_reg;
        m_valid_next    = m_valid_reg;
        m_data_next     = m_data_reg;

        mem_wr      = '0;
        mem_wr_addr = clr_addr_reg;
        mem_wr_data = 8'h00;
        mem_rd_addr = issue_reg[ADDR_W-1:0];

        // Drop the result once the downstream side takes it
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR: begin
                // Zero one byte of both maps per cycle
                mem_wr.wr_inode = 1'b1;
                mem_wr.wr_block = 1'b1;
                clr_addr_next   = clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next       = s_data.kind;
                    map_next        = s_data.map_select;
                    mark_addr_next  = ADDR_W'(slot_pos >> 3);
                    mark_bit_next   = slot_pos[2:0];
                    nbytes_next     = NB_W'(eff_size >> 3);
                    issue_next      = '0;
                    pend_next       = 1'b0;
                    res_status_next = bma_pkg::STATUS_OK;
                    res_found_next  = '0;
                    unique case (s_data.kind)
                        bma_pkg::KIND_FIND: begin
                            state_next = ST_SCAN;
                        end
                        bma_pkg::KIND_MARK_USED, bma_pkg::KIND_MARK_FREE: begin
                            if (slot_bad) begin
                                res_status_next = bma_pkg::STATUS_BAD_SLOT;
                                state_next      = ST_FIN;
                            end else begin
                                state_next = ST_MREAD;
                            end
                        end
                        default: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // Stream bytes out of the map, stop at the first one with a clear bit or when all bytes are read
                priority if (pend_reg && (rd_byte != 8'hFF)) begin
                    res_found_next = bma_pkg::SLOT_W'(found_sum);
                    state_next     = ST_FIN;
                end else if (!pend_reg && (issue_reg == nbytes_reg)) begin
                    res_status_next = bma_pkg::STATUS_NO_FREE;
                    state_next      = ST_FIN;
                end else if (issue_reg != nbytes_reg) begin
                    pend_next      = 1'b1;
                    pend_addr_next = issue_reg;
                    issue_next     = issue_reg + NB_W'(1);
                end else begin
                    pend_next = 1'b0;
                end
            end
            ST_MREAD: begin
                mem_rd_addr = mark_addr_reg;
                state_next  = ST_MWRITE;
            end
            ST_MWRITE: begin
                // Modify the fetched byte, write it back, move the counter
                mem_wr_addr     = mark_addr_reg;
                mem_wr.wr_inode = (map_reg == bma_pkg::MAP_INODE);
                mem_wr.wr_block = (map_reg == bma_pkg::MAP_BLOCK);
                if (kind_reg == bma_pkg::KIND_MARK_USED) begin
                    mem_wr_data = rd_byte | bit_mask;
                    if (map_reg == bma_pkg::MAP_BLOCK) begin
                        blk_free_next = blk_free_reg - bma_pkg::COUNT_W'(1);
                    end else begin
                        ino_free_next = ino_free_reg - bma_pkg::COUNT_W'(1);
                    end
                end else begin
                    mem_wr_data = rd_byte & ~bit_mask;
                    if (map_reg == bma_pkg::MAP_BLOCK) begin
                        blk_free_next = blk_free_reg + bma_pkg::COUNT_W'(1);
                    end else begin
                        ino_free_next = ino_free_reg + bma_pkg::COUNT_W'(1);
                    end
                end
                state_next = ST_FIN;
            end
            ST_FIN: begin
                // Hold until the result register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_data_next.status       = res_status_reg;
                    m_data_next.found_number = res_found_reg;
                    m_data_next.free_count   = count_sel;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State, counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_addr_reg <= '0;
            pend_reg     <= 1'b0;
            ino_free_reg <= '0;
            blk_free_reg <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_addr_reg <= clr_addr_next;
            pend_reg     <= pend_next;
            ino_free_reg <= ino_free_next;
            blk_free_reg <= blk_free_next;
            m_valid_reg  <= m_valid_next;
        end
        kind_reg       <= kind_next;
        map_reg        <= map_next;
        mark_addr_reg  <= mark_addr_next;
        mark_bit_reg   <= mark_bit_next;
        nbytes_reg     <= nbytes_next;
        issue_reg      <= issue_next;
        pend_addr_reg  <= pend_addr_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        m_data_reg     <= m_data_next;
    end

    // Outside the clearing pass only one map is written at a time
    `BMA_ASSERT_IMPL(a_one_map_wr, state_reg != ST_CLEAR, !(mem_wr.wr_inode && mem_wr.wr_block), "both maps written outside clear")
    // A write-back always follows its own read
    `BMA_ASSERT_IMPL(a_rmw_order, state_reg == ST_MWRITE, $past(state_reg) == ST_MREAD, "write-back without preceding read")
    // An accepted beat starts work
    `BMA_ASSERT_NEXT(a_accept_busy, s_valid && s_ready, state_reg != ST_IDLE, "accepted beat left no work")
    // A failed request reports no number
    `BMA_ASSERT_IMPL(a_fail_no_num, m_valid_reg && (m_data_reg.status != bma_pkg::STATUS_OK), m_data_reg.found_number == '0, "number reported on failure")

endmodule

/* rtl/core/bitmap_allocator.sv */
// ----------------------------------------------------------------------------
// bitmap_allocator
// Two-map bitmap free-space allocator with find, mark-used and mark-free.
//
//   Channel   Dir  Handshake           Payload
//   s_        in   s_valid / s_ready   bma_pkg::req_t  (kind, map_select, slot_number)
//   m_        out  m_valid / m_ready   bma_pkg::rsp_t  (status, found_number, free_count)
//   cfg_      in   cfg_we              cfg_index, cfg_wdata (size registers)
//
// A find scans the first floor(size/8) bytes of the selected map, reading one
// map byte per cycle from the bitmap memory port. A mark reads the byte, writes
// it back and then gives the result. After reset a clearing pass zeroes both
// maps; no beat is accepted during it. One request is in flight at a time; a result
// waiting on m_ready holds the next request in its last step.
// ----------------------------------------------------------------------------
module bitmap_allocator #(
    parameter int MAP_BYTES = bma_pkg::DEF_MAP_BYTES
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bma_pkg::req_t               s_data,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bma_pkg::rsp_t               m_data,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [bma_pkg::TOTAL_W-1:0] cfg_wdata
);

    localparam int ADDR_W = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

    logic [bma_pkg::TOTAL_W-1:0] inode_total_reg;
    logic [bma_pkg::TOTAL_W-1:0] block_total_reg;
    bma_pkg::mem_wr_t            mem_wr;
    logic [ADDR_W-1:0]           mem_wr_addr;
    logic [7:0]                  mem_wr_data;
    logic [ADDR_W-1:0]           mem_rd_addr;
    logic [7:0]                  inode_rd_data;
    logic [7:0]                  block_rd_data;

    // Size registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            inode_total_reg <= bma_pkg::INODE_TOTAL_RST;
            block_total_reg <= bma_pkg::BLOCK_TOTAL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bma_pkg::REG_INODE_TOTAL: inode_total_reg <= cfg_wdata;
                bma_pkg::REG_BLOCK_TOTAL: block_total_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    bma_ctrl #(
        .MAP_BYTES (MAP_BYTES)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .inode_total   (inode_total_reg),
        .block_total   (block_total_reg),
        .mem_wr        (mem_wr),
        .mem_wr_addr   (mem_wr_addr),
        .mem_wr_data   (mem_wr_data),
        .mem_rd_addr   (mem_rd_addr),
        .inode_rd_data (inode_rd_data),
        .block_rd_data (block_rd_data)
    );

    bma_map_ram #(
        .DEPTH (MAP_BYTES)
    ) u_inode_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr.wr_inode),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (inode_rd_data)
    );

    bma_map_ram #(
        .DEPTH (MAP_BYTES)
    ) u_block_ram (
        .aclk    (aclk),
        .wr_en   (mem_wr.wr_block),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_addr (mem_rd_addr),
        .rd_data (block_rd_data)
    );

endmodule
